// ===== sv/assert_macros.svh =====
// assertion helpers for the block's port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/aca_pkg.sv =====
// ----------------------------------------------------------------------------
// aca_pkg
// types and constants shared by the automaton controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none
package aca_pkg;
   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;
   localparam int NW       = $clog2(NODES);
   localparam int CW       = NW + 1;
   localparam int SW       = 5;
   localparam int GW       = NW + SW;
   localparam int GDEPTH   = NODES * 32;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_FINALIZE = 2'd1,
      OP_MATCH    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_INS_RD, ST_INS_WAIT, ST_INS_DO, ST_MAT_RD, ST_MAT_WAIT,
      ST_MAT_DO, ST_DONE, ST_F_INIT, ST_F_HEAD, ST_F_RD, ST_F_WAIT, ST_F_CHILD,
      ST_F_WALK_RD, ST_F_WALK_WAIT, ST_F_WALK, ST_F_NEXT, ST_G_INIT, ST_G_HEAD,
      ST_G_RD, ST_G_WAIT, ST_G_CHILD, ST_G_FRD, ST_G_FWAIT, ST_G_FILL, ST_G_NEXT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic clr_step;
      logic rd_ins;
      logic rd_mat;
      logic ins_do;
      logic mat_do;
      logic q_init;
      logic q_pop;
      logic rd_head;
      logic child_do;
      logic walk_rd;
      logic walk_step;
      logic sym_next;
      logic fill_rd;
      logic fill_wr;
      logic pass2;
      logic rsp_fin;
      logic done;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic q_empty;
      logic sym_last;
      logic child_nz;
      logic walk_hit;
      logic walk_end;
      logic at_root;
   } sts_type;
endpackage
`default_nettype wire

// ===== sv/aho_corasick_automaton.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_automaton
// multi-pattern trie with failure links and a match cursor
// ----------------------------------------------------------------------------
// usage: drive req_operation, req_symbol and req_restart with start high; a
// word is taken at a clock edge where start is high and busy is low.
// one result word per request appears on rsp_node, rsp_node_count and
// rsp_full_res for one cycle, marked by rsp_valid; it cannot be held off.
// insert and match go through a registered read of the goto memory, held
// over a wait state, then the update, then the result register.
// finalize walks the trie twice breadth-first over the single goto memory
// port: each symbol slot of each queued node is read, each filled slot takes
// one more read and write, plus the failure walk of the first pass.
// after reset the goto memory is cleared one entry a cycle, all NODES*32
// entries; busy stays high meanwhile.
// unused operation codes return node 0.
// ----------------------------------------------------------------------------
`default_nettype none
module aho_corasick_automaton (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_operation,
   input  wire logic [aca_pkg::SW-1:0] req_symbol,
   input  wire logic                   req_restart,
   output logic                        rsp_valid,
   output logic [aca_pkg::NW-1:0]      rsp_node,
   output logic [aca_pkg::CW-1:0]      rsp_node_count,
   output logic                        rsp_full_res
);
   import aca_pkg::*;

   cmd_type cmd;
   sts_type sts;

   aca_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_operation),
      .sts(sts), .busy(busy), .cmd(cmd)
   );

   aca_dpath u_dpath (
      .clock(clock), .reset(reset), .symbol(req_symbol),
      .restart(req_restart), .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid),
      .rsp_node(rsp_node), .rsp_node_count(rsp_node_count),
      .rsp_full_res(rsp_full_res)
   );
endmodule
`default_nettype wire

// ===== sv/aca_ctrl.sv =====
// ----------------------------------------------------------------------------
// aca_ctrl
// sequencer for clearing, insert, match and the two breadth-first passes
// ----------------------------------------------------------------------------
`default_nettype none
module aca_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [1:0]       op,
   input  wire aca_pkg::sts_type sts,
   output logic                  busy,
   output aca_pkg::cmd_type      cmd
);
   import aca_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(op))
                  OP_INSERT:   state_in = ST_INS_RD;
                  OP_MATCH:    state_in = ST_MAT_RD;
                  OP_FINALIZE: state_in = ST_F_INIT;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_RD:   state_in = ST_INS_WAIT;
         ST_INS_WAIT: state_in = ST_INS_DO;
         ST_INS_DO:   state_in = ST_DONE;
         ST_MAT_RD:   state_in = ST_MAT_WAIT;
         ST_MAT_WAIT: state_in = ST_MAT_DO;
         ST_MAT_DO:   state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         ST_F_INIT:   state_in = ST_F_RD;
         ST_F_HEAD:   state_in = sts.q_empty ? ST_G_INIT : ST_F_RD;
         ST_F_RD:     state_in = ST_F_WAIT;
         ST_F_WAIT:   state_in = ST_F_CHILD;
         // children of the root take the root as failure target, no walk
         ST_F_CHILD:  state_in = (sts.child_nz && !sts.at_root) ? ST_F_WALK_RD : ST_F_NEXT;
         ST_F_WALK_RD:   state_in = ST_F_WALK_WAIT;
         ST_F_WALK_WAIT: state_in = ST_F_WALK;
         ST_F_WALK:  state_in = (sts.walk_hit || sts.walk_end) ? ST_F_NEXT : ST_F_WALK_RD;
         ST_F_NEXT:  state_in = sts.sym_last ? ST_F_HEAD : ST_F_RD;
         ST_G_INIT:  state_in = ST_G_RD;
         ST_G_HEAD:  state_in = sts.q_empty ? ST_DONE : ST_G_RD;
         ST_G_RD:    state_in = ST_G_WAIT;
         ST_G_WAIT:  state_in = ST_G_CHILD;
         // the root row is never filled
         ST_G_CHILD: state_in = (sts.child_nz || sts.at_root) ? ST_G_NEXT : ST_G_FRD;
         ST_G_FRD:   state_in = ST_G_FWAIT;
         ST_G_FWAIT: state_in = ST_G_FILL;
         ST_G_FILL:  state_in = ST_G_NEXT;
         ST_G_NEXT:  state_in = sts.sym_last ? ST_G_HEAD : ST_G_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR:    cmd.clr_step = 1'b1;
         ST_IDLE:     cmd.capture = start;
         // read address is held through the wait cycle
         ST_INS_RD, ST_INS_WAIT: cmd.rd_ins = 1'b1;
         ST_INS_DO:   cmd.ins_do = 1'b1;
         ST_MAT_RD, ST_MAT_WAIT: cmd.rd_mat = 1'b1;
         ST_MAT_DO:   cmd.mat_do = 1'b1;
         ST_DONE:     cmd.done = 1'b1;
         ST_F_INIT:   cmd.q_init = 1'b1;
         ST_F_HEAD:   cmd.q_pop = !sts.q_empty;
         ST_F_RD:     cmd.rd_head = 1'b1;
         ST_F_CHILD:  cmd.child_do = 1'b1;
         ST_F_WALK_RD, ST_F_WALK_WAIT: cmd.walk_rd = 1'b1;
         ST_F_WALK:   cmd.walk_step = 1'b1;
         ST_F_NEXT:   cmd.sym_next = 1'b1;
         ST_G_INIT: begin
            cmd.q_init = 1'b1;
            cmd.pass2  = 1'b1;
         end
         ST_G_HEAD: begin
            cmd.q_pop   = !sts.q_empty;
            cmd.pass2   = 1'b1;
            cmd.rsp_fin = sts.q_empty;
         end
         ST_G_RD: begin
            cmd.rd_head = 1'b1;
            cmd.pass2   = 1'b1;
         end
         ST_G_CHILD: begin
            cmd.child_do = 1'b1;
            cmd.pass2    = 1'b1;
         end
         ST_G_FRD, ST_G_FWAIT: cmd.fill_rd = 1'b1;
         ST_G_FILL:  cmd.fill_wr = 1'b1;
         ST_G_NEXT: begin
            cmd.sym_next = 1'b1;
            cmd.pass2    = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/aca_dpath.sv =====
// ----------------------------------------------------------------------------
// aca_dpath
// goto table, failure links, queue, cursors and the result register
// ----------------------------------------------------------------------------
`default_nettype none
module aca_dpath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [aca_pkg::SW-1:0]   symbol,
   input  wire logic                     restart,
   input  wire aca_pkg::cmd_type         cmd,
   output aca_pkg::sts_type              sts,
   output logic                          rsp_valid,
   output logic [aca_pkg::NW-1:0]        rsp_node,
   output logic [aca_pkg::CW-1:0]        rsp_node_count,
   output logic                          rsp_full_res
);
   import aca_pkg::*;

   localparam int QW = NW + 1;

   // goto table, row per node, 32 symbol slots per row
   logic [NW-1:0] gmem [GDEPTH];
   logic [NW-1:0] fmem [NODES];
   logic [NW-1:0] qmem [NODES];

   logic [GW-1:0] g_addr;
   logic          g_we;
   logic [NW-1:0] g_wd;
   logic [NW-1:0] g_rd_ff;
   logic [NW-1:0] f_addr;
   logic          f_we;
   logic [NW-1:0] f_wd;
   logic [NW-1:0] f_rd_ff;
   logic [NW-1:0] q_addr;
   logic          q_we;
   logic [NW-1:0] q_rd_ff;

   logic [GW-1:0] clr_ff;
   logic [SW-1:0] sym_ff;
   logic          rst_ff;
   logic [NW-1:0] icur_ff, mcur_ff;
   logic [CW-1:0] alloc_ff;
   logic [QW-1:0] head_ff, tail_ff;
   logic [NW-1:0] h_ff;     // node being expanded
   logic [NW-1:0] hf_ff;    // failure link of h
   logic [NW-1:0] c_ff;     // current child
   logic [NW-1:0] t_ff;     // failure walk node
   logic [CW-1:0] steps_ff;
   logic [SW-1:0] s_ff;
   logic          head_root_ff;
   logic          wait_h_ff;  // head pop pending: queue and link data arrive
   logic          out_v_ff, out_full_ff;
   logic [NW-1:0] out_node_ff;

   logic [NW-1:0] cur_ins, cur_mat;
   logic          sym_ok;
   logic          q_full;

   assign sym_ok  = (sym_ff < SW'(ALPHABET));
   assign cur_ins = rst_ff ? '0 : icur_ff;
   assign cur_mat = rst_ff ? '0 : mcur_ff;
   assign q_full  = (tail_ff == QW'(NODES));

   // head node of the expansion is the root during queue init
   logic [NW-1:0] row;
   assign row = head_root_ff ? '0 : h_ff;

   always_comb begin
      g_addr = {row, s_ff};
      g_we   = 1'b0;
      g_wd   = '0;
      f_addr = c_ff;
      f_we   = 1'b0;
      f_wd   = '0;
      q_addr = head_ff[NW-1:0];
      q_we   = 1'b0;
      if (cmd.clr_step) begin
         g_addr = clr_ff;
         g_we   = 1'b1;
      end else if (cmd.rd_ins) begin
         g_addr = {cur_ins, sym_ff};
      end else if (cmd.rd_mat) begin
         g_addr = {cur_mat, sym_ff};
      end else if (cmd.ins_do) begin
         g_addr = {cur_ins, sym_ff};
         g_we   = sym_ok && (g_rd_ff == '0) && (alloc_ff != CW'(NODES));
         g_wd   = alloc_ff[NW-1:0];
      end else if (cmd.walk_rd) begin
         g_addr = {t_ff, s_ff};
         f_addr = t_ff;
      end else if (cmd.fill_rd) begin
         g_addr = {hf_ff, s_ff};
      end else if (cmd.fill_wr) begin
         g_we   = 1'b1;
         g_wd   = g_rd_ff;
      end
      if (cmd.q_pop) f_addr = q_rd_ff;
      if (cmd.walk_step) begin
         // link is written once, when the walk ends
         f_addr = c_ff;
         f_we   = sts.walk_hit || sts.walk_end;
         f_wd   = (g_rd_ff != '0) ? g_rd_ff : '0;
      end else if (cmd.child_do && !cmd.pass2 && head_root_ff && g_rd_ff != '0) begin
         f_addr = g_rd_ff;
         f_we   = 1'b1;
         f_wd   = '0;
      end
      if (cmd.child_do && g_rd_ff != '0 && !q_full) begin
         q_addr = tail_ff[NW-1:0];
         q_we   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (g_we) gmem[g_addr] <= g_wd;
      g_rd_ff <= gmem[g_addr];
      if (f_we) fmem[f_addr] <= f_wd;
      f_rd_ff <= fmem[f_addr];
      if (q_we) qmem[q_addr] <= g_rd_ff;
      q_rd_ff <= qmem[q_addr];
   end

   logic walk_last;
   assign walk_last = (steps_ff == CW'(NODES - 1));
   assign sts.clr_last = (clr_ff == GW'(GDEPTH - 1));
   assign sts.q_empty  = !head_root_ff && (head_ff == tail_ff);
   assign sts.sym_last = (s_ff == SW'(ALPHABET - 1));
   assign sts.child_nz = (g_rd_ff != '0);
   assign sts.walk_hit = (g_rd_ff != '0);
   assign sts.walk_end = (t_ff == '0) || walk_last;
   assign sts.at_root  = head_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         icur_ff   <= '0;
         mcur_ff   <= '0;
         alloc_ff  <= CW'(1);
         out_v_ff  <= 1'b0;
         head_root_ff <= 1'b0;
         wait_h_ff <= 1'b0;
      end else begin
         out_v_ff <= 1'b0;
         if (cmd.clr_step) clr_ff <= clr_ff + GW'(1);
         if (cmd.capture) begin
            sym_ff <= symbol;
            rst_ff <= restart;
            out_node_ff <= '0;
            out_full_ff <= 1'b0;
         end
         if (cmd.ins_do) begin
            if (!sym_ok) begin
               icur_ff <= cur_ins;
               out_node_ff <= cur_ins;
            end else if (g_rd_ff != '0) begin
               icur_ff <= g_rd_ff;
               out_node_ff <= g_rd_ff;
            end else if (alloc_ff != CW'(NODES)) begin
               alloc_ff <= alloc_ff + CW'(1);
               icur_ff <= alloc_ff[NW-1:0];
               out_node_ff <= alloc_ff[NW-1:0];
            end else begin
               icur_ff <= cur_ins;
               out_node_ff <= cur_ins;
               out_full_ff <= 1'b1;
            end
         end
         if (cmd.mat_do) begin
            mcur_ff <= sym_ok ? g_rd_ff : '0;
            out_node_ff <= sym_ok ? g_rd_ff : '0;
         end
         if (cmd.q_init) begin
            head_ff <= '0;
            tail_ff <= '0;
            head_root_ff <= 1'b1;
            s_ff <= '0;
         end
         if (cmd.q_pop) begin
            head_ff <= head_ff + QW'(1);
            wait_h_ff <= 1'b1;
         end
         if (cmd.rd_head && wait_h_ff) begin
            // queue data and its failure link arrived last cycle
            h_ff <= q_rd_ff;
            hf_ff <= f_rd_ff;
            wait_h_ff <= 1'b0;
            s_ff <= '0;
         end
         // a self edge rewrites the link of the node being expanded
         if (cmd.walk_step && f_we && c_ff == h_ff) hf_ff <= f_wd;
         if (cmd.child_do) begin
            c_ff <= g_rd_ff;
            t_ff <= head_root_ff ? '0 : hf_ff;
            steps_ff <= '0;
            if (g_rd_ff != '0 && !q_full) tail_ff <= tail_ff + QW'(1);
         end
         if (cmd.walk_step && !(g_rd_ff != '0) && !sts.walk_end) begin
            t_ff <= f_rd_ff;
            steps_ff <= steps_ff + CW'(1);
         end
         if (cmd.sym_next) begin
            if (sts.sym_last) head_root_ff <= 1'b0;
            else s_ff <= s_ff + SW'(1);
         end
         if (cmd.done) out_v_ff <= 1'b1;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_node       = out_node_ff;
   assign rsp_node_count = alloc_ff;
   assign rsp_full_res   = out_full_ff;
endmodule
`default_nettype wire

// ===== sv/aca_checker.sv =====
// ----------------------------------------------------------------------------
// aca_checker
// port-level checks on the automaton
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module aca_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [aca_pkg::CW-1:0] rsp_node_count,
   input wire logic                   rsp_full_res
);
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_result_when_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && rsp_full_res,
      rsp_node_count == aca_pkg::CW'(aca_pkg::NODES))
endmodule

bind aho_corasick_automaton aca_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_node_count(rsp_node_count),
   .rsp_full_res(rsp_full_res)
);
`default_nettype wire

// ===== bench/aho_corasick_automaton_tb.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_automaton_tb
// checks the trie automaton against a cycle-free predictor of its state
// ----------------------------------------------------------------------------
// a queue of pending words is filled by the stimulus process and fed to the
// block by a clocked driver; every accepted word updates the predicted trie,
// failure links and cursors and queues the expected result word, which the
// monitor compares field by field with each strobed result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module aho_corasick_automaton_tb;
   import aca_pkg::*;

   // a finalize over a full trie with the longest failure walks
   localparam int WATCHDOG_CYCLES = 400000000;

   typedef struct {
      op_type     op;
      logic [4:0] sym;
      logic       rst;
   } req_word_type;

   typedef struct {
      logic [NW-1:0] node;
      logic [CW-1:0] count;
      logic          full;
   } rsp_word_type;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic [1:0]      req_operation;
   logic [SW-1:0]   req_symbol;
   logic            req_restart;
   logic            rsp_valid;
   logic [NW-1:0]   rsp_node;
   logic [CW-1:0]   rsp_node_count;
   logic            rsp_full_res;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   bit           failed;
   bit           quiet;
   int           gap;
   int           stall_count;

   // predicted automaton state
   logic [NW-1:0] trie_edge [0:NODES-1][0:31];
   logic [NW-1:0] fail_link [0:NODES-1];
   logic [NW-1:0] walk_queue [0:NODES-1];
   int unsigned   used_nodes;
   logic [NW-1:0] ins_cursor;
   logic [NW-1:0] mat_cursor;

   aho_corasick_automaton i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_symbol(req_symbol),
      .req_restart(req_restart), .rsp_valid(rsp_valid), .rsp_node(rsp_node),
      .rsp_node_count(rsp_node_count), .rsp_full_res(rsp_full_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // follow failure links until a node with the edge turns up, root as fallback
   function automatic logic [NW-1:0] link_target(int unsigned t, int unsigned s);
      for (int n = 0; n < NODES; n++) begin
         if (trie_edge[t][s] != '0) return trie_edge[t][s];
         if (t == 0) return '0;
         t = fail_link[t];
      end
      return '0;
   endfunction

   task automatic build_links();
      int unsigned head;
      int unsigned tail;
      int unsigned h;
      logic [NW-1:0] c;
      head = 0;
      tail = 0;
      for (int s = 0; s < ALPHABET; s++) begin
         c = trie_edge[0][s];
         if (c != '0 && tail < NODES) begin
            walk_queue[tail] = c;
            tail++;
            fail_link[c] = '0;
         end
      end
      while (head < tail) begin
         h = walk_queue[head];
         head++;
         for (int s = 0; s < ALPHABET; s++) begin
            c = trie_edge[h][s];
            if (c != '0) begin
               if (tail < NODES) begin
                  walk_queue[tail] = c;
                  tail++;
               end
               fail_link[c] = link_target(h == 0 ? 0 : fail_link[h], s);
            end
         end
      end
      // second pass fills the missing edges from the failure targets
      head = 0;
      tail = 0;
      for (int s = 0; s < ALPHABET; s++) begin
         c = trie_edge[0][s];
         if (c != '0 && tail < NODES) begin
            walk_queue[tail] = c;
            tail++;
         end
      end
      while (head < tail) begin
         h = walk_queue[head];
         head++;
         for (int s = 0; s < ALPHABET; s++) begin
            c = trie_edge[h][s];
            if (c != '0) begin
               if (tail < NODES) begin
                  walk_queue[tail] = c;
                  tail++;
               end
            end else begin
               trie_edge[h][s] = trie_edge[fail_link[h]][s];
            end
         end
      end
   endtask

   task automatic apply_word(req_word_type w);
      rsp_word_type r;
      logic [NW-1:0] cur;
      r.node = '0;
      r.full = 1'b0;
      case (w.op)
         OP_INSERT: begin
            cur = w.rst ? '0 : ins_cursor;
            if (w.sym < ALPHABET) begin
               if (trie_edge[cur][w.sym] == '0) begin
                  if (used_nodes < NODES) begin
                     trie_edge[cur][w.sym] = used_nodes[NW-1:0];
                     used_nodes++;
                  end else begin
                     r.full = 1'b1;
                  end
               end
               if (!r.full) cur = trie_edge[cur][w.sym];
            end
            ins_cursor = cur;
            r.node = cur;
         end
         OP_FINALIZE: build_links();
         OP_MATCH: begin
            cur = w.rst ? '0 : mat_cursor;
            cur = (w.sym < ALPHABET) ? trie_edge[cur][w.sym] : '0;
            mat_cursor = cur;
            r.node = cur;
         end
         default: ;
      endcase
      r.count = used_nodes[CW-1:0];
      expected_words.push_back(r);
   endtask

   task automatic send(op_type op, int sym, bit rst);
      req_word_type w;
      w.op = op;
      w.sym = sym[4:0];
      w.rst = rst;
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clock);
   endtask

   // driver: the word at the head of the queue stays on the ports until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
      end else begin
         if (start && !busy) begin
            apply_word(pending_words.pop_front());
         end
         if (start && busy) begin
            // hold the current word
         end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            gap <= $urandom_range(1, 7) - 1;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            start <= 1'b1;
            req_operation <= pending_words[0].op;
            req_symbol <= pending_words[0].sym;
            req_restart <= pending_words[0].rst;
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         failed = 1'b1;
      end
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, node %0d", $time, rsp_node);
            failed = 1'b1;
         end else begin
            e = expected_words.pop_front();
            check_field("node", e.node, rsp_node);
            check_field("node_count", e.count, rsp_node_count);
            check_field("full_res", e.full, rsp_full_res);
         end
      end
      if (rsp_valid || (start && !busy)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_CYCLES) begin
         $display("%0t: watchdog expired", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int sym;
      for (int n = 0; n < NODES; n++) begin
         for (int s = 0; s < 32; s++) trie_edge[n][s] = '0;
         fail_link[n] = '0;
         walk_queue[n] = '0;
      end
      used_nodes = 1;
      ins_cursor = '0;
      mat_cursor = '0;
      failed = 1'b0;
      quiet = 1'b0;
      stall_count = 0;
      start = 1'b0;
      req_operation = OP_NONE;
      req_symbol = '0;
      req_restart = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: match before finalize, unused code, edges, out of range symbols
      send(OP_MATCH, 0, 1);
      send(OP_NONE, 31, 1);
      send(OP_INSERT, 0, 1);
      send(OP_INSERT, 25, 0);
      send(OP_INSERT, 31, 0);
      send(OP_INSERT, 26, 1);
      send(OP_INSERT, 0, 1);
      send(OP_INSERT, 1, 0);
      send(OP_INSERT, 25, 1);
      send(OP_INSERT, 0, 0);
      send(OP_INSERT, 1, 0);
      send(OP_FINALIZE, 0, 0);
      send(OP_MATCH, 25, 1);
      send(OP_MATCH, 0, 0);
      send(OP_MATCH, 1, 0);
      send(OP_MATCH, 25, 0);
      send(OP_MATCH, 31, 0);
      send(OP_MATCH, 0, 0);
      send(OP_MATCH, 1, 1);
      send(OP_NONE, 0, 0);
      send(OP_MATCH, 16, 1);
      drain();

      // inserts after finalize, then one repeated finalize over the filled graph
      for (int i = 0; i < 60; i++) begin
         sym = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
         send(OP_INSERT, sym, $urandom_range(0, 4) == 0);
      end
      send(OP_FINALIZE, 0, 0);
      for (int i = 0; i < 60; i++) begin
         case ($urandom_range(0, 19))
            0: send(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 1));
            1: send(OP_INSERT, $urandom_range(0, 31), $urandom_range(0, 1));
            2: send(OP_MATCH, $urandom_range(26, 31), $urandom_range(0, 1));
            default: send(OP_MATCH, $urandom_range(0, 9), $urandom_range(0, 15) == 0);
         endcase
      end
      drain();

      // grow the trie until no node is left
      while (used_nodes < NODES) begin
         for (int i = 0; i < 64; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send(OP_MATCH, $urandom_range(0, 31), $urandom_range(0, 7) == 0);
            end else begin
               sym = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 25);
               send(OP_INSERT, sym, $urandom_range(0, 31) == 0);
            end
         end
         drain();
      end

      // full trie, no idling from here on
      quiet = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0) send(OP_INSERT, $urandom_range(0, 31), $urandom_range(0, 7) == 0);
         else send(OP_MATCH, $urandom_range(0, 31), $urandom_range(0, 7) == 0);
      end
      drain();
      repeat (20) @(posedge clock);
      if (!failed) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/aca_pkg.sv
sv/aca_ctrl.sv
sv/aca_dpath.sv
sv/aho_corasick_automaton.sv
sv/aca_checker.sv
bench/aho_corasick_automaton_tb.sv
